// ===== hdl/mapper_irq_timer_and_bank_regs_top_macros.svh =====
// Assertion macros shared by the mapper IRQ timer block.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef MAPPER_IRQ_TIMER_AND_BANK_REGS_TOP_MACROS_SVH
`define MAPPER_IRQ_TIMER_AND_BANK_REGS_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MITB_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define MITB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MITB_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define MITB_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== hdl/mitb_pkg.sv =====
// Shared types and constants for the mapper IRQ timer and bank register block.
// No dependencies.
package mitb_pkg;

  localparam logic [15:0] ADDR_CTRL     = 16'h4032;
  localparam logic [15:0] ADDR_LATCH_LO = 16'h4034;
  localparam logic [15:0] ADDR_LATCH_HI = 16'h4035;
  localparam logic [15:0] ADDR_BANK_LO  = 16'h4040;

  localparam int CNT_W   = 18;
  localparam int LATCH_W = 16;

  // Classified operation codes
  localparam logic [2:0] OP_NONE     = 3'd0;
  localparam logic [2:0] OP_CTRL     = 3'd1;
  localparam logic [2:0] OP_LATCH_LO = 3'd2;
  localparam logic [2:0] OP_LATCH_HI = 3'd3;
  localparam logic [2:0] OP_BANK     = 3'd4;
  localparam logic [2:0] OP_TICK     = 3'd5;

  // Control register bits
  localparam int CTRL_REPEAT_BIT = 0;
  localparam int CTRL_ENABLE_BIT = 1;

  typedef struct packed {
    logic        cmd;
    logic [15:0] bus_address;
    logic [7:0]  write_data;
    logic [7:0]  tick_cycles;
  } req_word_t;

  typedef struct packed {
    logic       irq_line;
    logic       bank_update;
    logic [2:0] bank_slot;
    logic [6:0] bank_number;
  } rsp_word_t;

  // Decoded op: data is the write byte, or the tick length for OP_TICK
  typedef struct packed {
    logic [2:0] kind;
    logic [2:0] slot;
    logic [7:0] data;
  } op_t;

endpackage

// ===== hdl/mitb_front.sv =====
// Front end: accepts request words, decodes address/command into an op.
// Depends on mitb_pkg.
module mitb_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  mitb_pkg::req_word_t req,
  output logic               op_valid,
  input  logic               op_ready,
  output mitb_pkg::op_t      op
);
  import mitb_pkg::*;

  op_t  op_dec;
  logic valid;

  always_comb begin
    op_dec.slot = req.bus_address[2:0];
    op_dec.data = req.write_data;
    if (req.cmd) begin
      op_dec.kind = OP_TICK;
      op_dec.data = req.tick_cycles;
    end else if (req.bus_address == ADDR_CTRL) begin
      op_dec.kind = OP_CTRL;
    end else if (req.bus_address == ADDR_LATCH_LO) begin
      op_dec.kind = OP_LATCH_LO;
    end else if (req.bus_address == ADDR_LATCH_HI) begin
      op_dec.kind = OP_LATCH_HI;
    end else if (req.bus_address[15:3] == ADDR_BANK_LO[15:3]) begin
      op_dec.kind = OP_BANK;
    end else begin
      op_dec.kind = OP_NONE;
    end
  end

  assign req_ready = !valid || op_ready;
  assign op_valid  = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (req_ready) begin
      valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      op <= op_dec;
    end
  end

endmodule

// ===== hdl/mitb_queue.sv =====
// Two-entry op queue between decode and execute.
// Depends on mitb_pkg and the assertion macro header.
`include "mapper_irq_timer_and_bank_regs_top_macros.svh"
module mitb_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  mitb_pkg::op_t push_op,
  output logic          pop_valid,
  input  logic          pop_ready,
  output mitb_pkg::op_t pop_op
);
  import mitb_pkg::*;

  op_t        slots [2];
  logic       head;
  logic       tail;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_op     = slots[head];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= 1'b0;
      tail  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) tail <= ~tail;
      if (pop)  head <= ~head;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[tail] <= push_op;
    end
  end

  `MITB_ASSERT_IMPLIES(a_q_bound, clk, rst, 1'b1, count <= 2'd2, "queue overfilled")

endmodule

// ===== hdl/mitb_exec.sv =====
// Back end: timer state, reload latch and bank report; registered response.
// Depends on mitb_pkg and the assertion macro header.
`include "mapper_irq_timer_and_bank_regs_top_macros.svh"
module mitb_exec (
  input  logic               clk,
  input  logic               rst,
  input  logic               op_valid,
  output logic               op_ready,
  input  mitb_pkg::op_t      op,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output mitb_pkg::rsp_word_t rsp
);
  import mitb_pkg::*;

  logic [LATCH_W-1:0]     latch, latch_next;
  logic signed [CNT_W-1:0] ctr, ctr_next;
  logic                   enabled, enabled_next;
  logic                   repeat_on, repeat_on_next;
  logic                   occurred, occurred_next;
  logic                   irq_level, irq_level_next;
  logic                   out_valid;
  rsp_word_t              rsp_next;
  logic                   pop;

  logic signed [CNT_W:0]   diff;
  logic signed [CNT_W-1:0] sat;
  logic                    expired;
  logic signed [CNT_W-1:0] reloaded;
  logic signed [CNT_W-1:0] latch_ext;

  // assertion helpers
  logic                    ctrl_en_pop;
  logic                    tick_pop;
  logic                    rsp_irq_ok;

  assign op_ready  = !out_valid || rsp_ready;
  assign pop       = op_valid && op_ready;
  assign rsp_valid = out_valid;
  assign latch_ext = $signed({{(CNT_W-LATCH_W){1'b0}}, latch});

  // Tick datapath: subtract, clamp at negative bound, test, add latch
  always_comb begin
    diff = {ctr[CNT_W-1], ctr} - $signed({{(CNT_W-7){1'b0}}, op.data});
    if (diff[CNT_W] && !diff[CNT_W-1]) begin
      sat = {1'b1, {(CNT_W-1){1'b0}}};
    end else begin
      sat = diff[CNT_W-1:0];
    end
    expired  = sat[CNT_W-1] || (sat == '0);
    reloaded = sat + latch_ext;
  end

  always_comb begin
    latch_next     = latch;
    ctr_next       = ctr;
    enabled_next   = enabled;
    repeat_on_next = repeat_on;
    occurred_next  = occurred;
    irq_level_next = irq_level;
    rsp_next       = '0;
    case (op.kind)
      OP_CTRL: begin
        repeat_on_next = op.data[CTRL_REPEAT_BIT];
        enabled_next   = op.data[CTRL_ENABLE_BIT];
        occurred_next  = 1'b0;
        if (op.data[CTRL_ENABLE_BIT]) begin
          ctr_next = latch_ext;
        end else begin
          irq_level_next = 1'b0;
        end
      end
      OP_LATCH_LO: latch_next = {latch[15:8], op.data};
      OP_LATCH_HI: latch_next = {op.data, latch[7:0]};
      OP_BANK: begin
        rsp_next.bank_update = 1'b1;
        rsp_next.bank_slot   = op.slot;
        rsp_next.bank_number = op.data[6:0];
      end
      OP_TICK: begin
        if (enabled) begin
          ctr_next = expired ? reloaded : sat;
          if (expired && !occurred) begin
            occurred_next  = 1'b1;
            irq_level_next = 1'b1;
            if (!repeat_on) enabled_next = 1'b0;
          end
        end
      end
      default: ;
    endcase
    rsp_next.irq_line = irq_level_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      latch     <= '0;
      ctr       <= '0;
      enabled   <= 1'b0;
      repeat_on <= 1'b0;
      occurred  <= 1'b0;
      irq_level <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (op_ready) out_valid <= op_valid;
      if (pop) begin
        latch     <= latch_next;
        ctr       <= ctr_next;
        enabled   <= enabled_next;
        repeat_on <= repeat_on_next;
        occurred  <= occurred_next;
        irq_level <= irq_level_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) rsp <= rsp_next;
  end

  assign ctrl_en_pop = pop && (op.kind == OP_CTRL) && op.data[CTRL_ENABLE_BIT];
  assign tick_pop    = pop && (op.kind == OP_TICK);
  assign rsp_irq_ok  = (rsp.irq_line == irq_level);

  `MITB_ASSERT_NEXT(a_ctrl_load, clk, rst, ctrl_en_pop, ctr == latch_ext, "counter not loaded")
  `MITB_ASSERT_IMPLIES(a_irq_src, clk, rst, $rose(irq_level), $past(tick_pop), "stray irq raise")
  `MITB_ASSERT_NEXT(a_pop_rsp, clk, rst, pop, out_valid && rsp_irq_ok, "no response after pop")

endmodule

// ===== hdl/mapper_irq_timer_and_bank_regs_top.sv =====
// rsp_valid rises after an accepted request word passes the decode register, a queue
// slot and the execute/response register, in that order; one word per cycle sustained
// while rsp_ready is held high, since a response stall holds the execute stage.
// Throughput is set by the execute stage, which does one subtract/clamp/add per word.
// Reset (rst, synchronous, active high) clears latch, counter, mode bits, IRQ level
// and all valid flags; the block is ready as soon as reset is released.
// Depends on mitb_pkg, mitb_front, mitb_queue, mitb_exec.
module mapper_irq_timer_and_bank_regs_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  mitb_pkg::req_word_t req,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output mitb_pkg::rsp_word_t rsp
);
  import mitb_pkg::*;

  // decode -> queue
  logic dec_valid;
  logic dec_ready;
  op_t  dec_op;

  // queue -> execute
  logic ex_valid;
  logic ex_ready;
  op_t  ex_op;

  // Front: registers one decoded op; accepts while its slot is free or draining
  mitb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .op_valid  (dec_valid),
    .op_ready  (dec_ready),
    .op        (dec_op)
  );

  // Two-entry queue lets decode keep taking words while the response stalls
  mitb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (dec_valid),
    .push_ready (dec_ready),
    .push_op    (dec_op),
    .pop_valid  (ex_valid),
    .pop_ready  (ex_ready),
    .pop_op     (ex_op)
  );

  // Back: timer/latch state and the response register
  mitb_exec u_exec (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (ex_valid),
    .op_ready  (ex_ready),
    .op        (ex_op),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule
